[rtl/core/gha_pkg.sv]
`timescale 1ns / 1ps

package gha_pkg;

	localparam int MAX_ENTITIES = 1024;
	localparam int ID_W = $clog2(MAX_ENTITIES);
	localparam int CNT_W = ID_W + 1;
	localparam int GEN_W = 32;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);

	localparam logic [1:0] ACT_CREATE = 2'd0;
	localparam logic [1:0] ACT_DESTROY = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DEAD = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_POP,
		S_EXEC
	} state_t;

endpackage

[rtl/core/gha_if.sv]
`timescale 1ns / 1ps

interface gha_req_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic [gha_pkg::ID_W-1:0]  entity_id;
	logic [gha_pkg::GEN_W-1:0] entity_generation;

	modport source (output valid, action, entity_id, entity_generation, input ready);
	modport sink (input valid, action, entity_id, entity_generation, output ready);
endinterface

interface gha_rsp_if;
	logic                    valid;
	logic                    ready;
	logic [gha_pkg::ID_W-1:0]  result_id;
	logic [gha_pkg::GEN_W-1:0] result_generation;
	logic                    alive;
	logic [1:0]              status;

	modport source (output valid, result_id, result_generation, alive, status, input ready);
	modport sink (input valid, result_id, result_generation, alive, status, output ready);
endinterface

[rtl/core/gha_ram.sv]
`timescale 1ns / 1ps

module gha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/generational_handle_allocator_top.sv]
`timescale 1ns / 1ps

// generational handle allocator
// req channel carries action (create, destroy, check alive), entity_id and
// entity_generation; rsp channel returns result_id, result_generation, alive
// and status, one rsp transfer for every req transfer, in order.
// each request walks a small sequencer around two registered-read memories:
// the generation table and the free-id stack. a request goes from its
// transfer through the read and exec states to its result transfer (a create
// that pops the free stack also passes a pop state, as it needs the stack read
// before the generation read); the next request is taken in the cycle after
// the previous result enters the output register, so the block never takes a
// new request before the previous result is stored.
// the output register holds a result while rsp is stalled, and a new request
// is still taken and worked up to the point where its result is stored; it
// then waits until the output register frees.
// reset clears the state, the output valid, the free count and high-water
// mark only; a create that takes a fresh slot writes a zero generation into
// it and entries at or above the high-water mark are never used, so no
// clearing pass is needed and the block takes requests right after reset.

module generational_handle_allocator_top (
	input  logic          clk,
	input  logic          arst_n,
	gha_req_if.sink       req,
	gha_rsp_if.source     rsp
);

	gha_pkg::state_t state_q, state_next;

	logic [1:0]                   act_q;
	logic [gha_pkg::ID_W-1:0]     id_q;
	logic [gha_pkg::GEN_W-1:0]    gen_q;
	logic [gha_pkg::ID_W-1:0]     slot_q;
	logic [gha_pkg::CNT_W-1:0]    free_count_q;
	logic [gha_pkg::CNT_W-1:0]    high_water_q;

	logic                         rsp_valid_q;
	logic [gha_pkg::ID_W-1:0]     rsp_id_q;
	logic [gha_pkg::GEN_W-1:0]    rsp_gen_q;
	logic                         rsp_alive_q;
	logic [1:0]                   rsp_status_q;

	logic                         gen_we;
	logic [gha_pkg::ID_W-1:0]     gen_waddr;
	logic [gha_pkg::GEN_W-1:0]    gen_wdata;
	logic [gha_pkg::ID_W-1:0]     gen_raddr;
	logic [gha_pkg::GEN_W-1:0]    gen_rdata;

	logic                         stk_we;
	logic [gha_pkg::ID_W-1:0]     stk_waddr;
	logic [gha_pkg::ID_W-1:0]     stk_raddr;
	logic [gha_pkg::ID_W-1:0]     stk_rdata;

	logic                         is_create;
	logic                         out_free;
	logic                         in_range;
	logic                         live;
	logic [gha_pkg::GEN_W-1:0]    gen_inc;
	logic [gha_pkg::CNT_W-1:0]    cnt_dec;

	logic                         req_ready;
	logic                         finish;
	logic [gha_pkg::ID_W-1:0]     res_id;
	logic [gha_pkg::GEN_W-1:0]    res_gen;
	logic                         res_alive;
	logic [1:0]                   res_status;
	logic                         pop;
	logic                         bump_hw;
	logic                         push;

	gha_ram #(
		.WIDTH (gha_pkg::GEN_W),
		.DEPTH (gha_pkg::MAX_ENTITIES)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gha_ram #(
		.WIDTH (gha_pkg::ID_W),
		.DEPTH (gha_pkg::MAX_ENTITIES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (id_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign is_create = (act_q == gha_pkg::ACT_CREATE);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign in_range = ({1'b0, id_q} < high_water_q);
	assign live = in_range && (gen_rdata == gen_q);
	assign gen_inc = gen_rdata + gha_pkg::GEN_W'(1);
	assign cnt_dec = free_count_q - gha_pkg::CNT_W'(1);

	// read addresses held steady while a result waits for the output register
	assign stk_raddr = cnt_dec[gha_pkg::ID_W-1:0];
	assign gen_raddr = (state_q == gha_pkg::S_POP) ? stk_rdata :
		(is_create ? slot_q : id_q);

	// a fresh slot gets a zero generation as it is handed out
	assign gen_waddr = bump_hw ? high_water_q[gha_pkg::ID_W-1:0] : id_q;
	assign gen_wdata = bump_hw ? '0 : gen_inc;
	assign stk_waddr = free_count_q[gha_pkg::ID_W-1:0];

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			gha_pkg::S_IDLE: begin
				if (req.valid) begin
					state_next = gha_pkg::S_READ;
				end
			end
			gha_pkg::S_READ: begin
				if (is_create && (free_count_q != '0)) begin
					state_next = gha_pkg::S_POP;
				end else begin
					state_next = gha_pkg::S_EXEC;
				end
			end
			gha_pkg::S_POP: begin
				state_next = gha_pkg::S_EXEC;
			end
			gha_pkg::S_EXEC: begin
				if (out_free) begin
					state_next = gha_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = gha_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		finish = 1'b0;
		pop = 1'b0;
		bump_hw = 1'b0;
		push = 1'b0;
		gen_we = 1'b0;
		stk_we = 1'b0;
		res_id = id_q;
		res_gen = '0;
		res_alive = 1'b0;
		res_status = gha_pkg::ST_OK;
		case (state_q)
			gha_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			gha_pkg::S_EXEC: begin
				finish = out_free;
				if (is_create) begin
					if (free_count_q != '0) begin
						pop = finish;
						res_id = slot_q;
						res_gen = gen_rdata;
					end else if (high_water_q < gha_pkg::MAX_CNT) begin
						bump_hw = finish;
						gen_we = finish;
						res_id = high_water_q[gha_pkg::ID_W-1:0];
					end else begin
						res_id = '0;
						res_status = gha_pkg::ST_FULL;
					end
				end else begin
					res_alive = live;
					res_gen = in_range ? gen_rdata : '0;
					if (!live) begin
						res_status = gha_pkg::ST_DEAD;
					end else if (act_q == gha_pkg::ACT_DESTROY) begin
						res_gen = gen_inc;
						gen_we = finish;
						push = finish && (free_count_q < gha_pkg::MAX_CNT);
						stk_we = push;
					end
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gha_pkg::S_IDLE;
			free_count_q <= '0;
			high_water_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (pop) begin
				free_count_q <= cnt_dec;
			end else if (push) begin
				free_count_q <= free_count_q + gha_pkg::CNT_W'(1);
			end
			if (bump_hw) begin
				high_water_q <= high_water_q + gha_pkg::CNT_W'(1);
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			act_q <= req.action;
			id_q <= req.entity_id;
			gen_q <= req.entity_generation;
		end
		if (state_q == gha_pkg::S_POP) begin
			slot_q <= stk_rdata;
		end
		if (finish) begin
			rsp_id_q <= res_id;
			rsp_gen_q <= res_gen;
			rsp_alive_q <= res_alive;
			rsp_status_q <= res_status;
		end
	end

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.result_id = rsp_id_q;
	assign rsp.result_generation = rsp_gen_q;
	assign rsp.alive = rsp_alive_q;
	assign rsp.status = rsp_status_q;

endmodule
